>>> rtl/slrs_pkg.sv
// Shared constants and types for the sliding least-squares slope block.
// No dependencies; every other file imports this package.
package slrs_pkg;

  localparam int CFG_W           = 9;
  localparam int MAX_WINDOW_DEF  = 256;
  localparam int SAMPLE_BITS_DEF = 32;
  localparam int MIN_WINDOW      = 2;
  localparam int SLOPE_W         = 32;
  localparam int DVD_W           = 64;   // numerator is kept modulo 2^64
  localparam int DVD_CNT_W       = $clog2(DVD_W);
  localparam int DEN_SCALE       = 12;   // den = n^2 (n^2 - 1) / 12

  localparam logic [CFG_W-1:0]   WINDOW_RESET = CFG_W'(14);
  localparam logic [SLOPE_W-1:0] SLOPE_POS_MAX = 32'h7FFF_FFFF;
  localparam logic [SLOPE_W-1:0] SLOPE_NEG_MAG = 32'h8000_0000;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> rtl/slrs_in_if.sv
// Input channel: one sample per transaction plus the series restart flag.
// Depends on slrs_pkg.
interface slrs_in_if import slrs_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          series_start;

  modport source (output valid, sample, series_start, input ready);
  modport sink   (input valid, sample, series_start, output ready);
endinterface

>>> rtl/slrs_out_if.sv
// Result channel: saturated signed integer (Q32.0) slope and its clip flag.
// Depends on slrs_pkg.
interface slrs_out_if import slrs_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [SLOPE_W-1:0] slope;
  logic                      saturated;

  modport source (output valid, slope, saturated, input ready);
  modport sink   (input valid, slope, saturated, output ready);
endinterface

>>> rtl/slrs_cfg_if.sv
// Configuration write channel carrying the window_length register.
// Depends on slrs_pkg.
interface slrs_cfg_if import slrs_pkg::*;;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] window_length;

  modport source (output valid, window_length, input ready);
  modport sink   (input valid, window_length, output ready);
endinterface

>>> rtl/slrs_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on slrs_pkg (DVD_W, div_stat_t).
module slrs_div import slrs_pkg::*; #(
  parameter int DEN_W = 36
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DEN_W-1:0] divisor_i,
  output div_stat_t        stat_o,
  output logic [DVD_W-1:0] quotient_o
);

  logic                 busy_q, done_q;
  logic [DVD_CNT_W-1:0] cnt_q;
  logic [DEN_W-1:0]     rem_q, sor_q;
  logic [DVD_W-1:0]     dq_q;

  logic [DEN_W:0]       rem_sh;
  logic [DEN_W+1:0]     diff;
  logic                 take;

  always_comb begin
    rem_sh = {rem_q, dq_q[DVD_W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, sor_q};
    take   = ~diff[DEN_W+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == DVD_CNT_W'(DVD_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // dq_q shifts the dividend out at the top and the quotient in at the bottom
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      sor_q <= divisor_i;
      dq_q  <= dividend_i;
    end else if (busy_q) begin
      rem_q <= take ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      dq_q  <= {dq_q[DVD_W-2:0], take};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = dq_q;

endmodule

>>> rtl/sliding_linear_regression_slope.sv
// Sliding least-squares slope. An item that yields a slope passes ST_RD, ST_MUL, ST_UPD,
// ST_NUM_A to ST_NUM_D, the 64-step serial divider and ST_OUT; the next item is taken once
// the result is registered. Items that only fill the window return to idle after ST_UPD.
// Reset is asynchronous, active low: window_length returns to 14 and the series restarts.
// After reset and after each window_length write, a setup pass (ST_INIT_A to ST_INIT_WAIT)
// computes the denominator on the same divider while the input is held off.
module sliding_linear_regression_slope import slrs_pkg::*; #(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  slrs_in_if.sink   samp_i,
  slrs_cfg_if.sink  cfg_i,
  slrs_out_if.source res_o
);

  localparam int NW     = $clog2(MAX_WINDOW + 1);
  localparam int PTR_W  = $clog2(MAX_WINDOW);
  localparam int SY_W   = (SAMPLE_BITS + PTR_W > DVD_W) ? DVD_W : SAMPLE_BITS + PTR_W;
  localparam int SXY_W  = (SAMPLE_BITS + 2 * PTR_W > DVD_W) ? DVD_W
                                                             : SAMPLE_BITS + 2 * PTR_W;
  localparam int N2_W   = 2 * NW;
  localparam int DEN_W  = 4 * NW;
  localparam int PRD_W  = SAMPLE_BITS + NW + 1;
  localparam int P1_W   = NW + 1 + SXY_W;
  localparam int P2_W   = N2_W + 1 + SY_W;
  localparam int IDX_W  = NW + 1;

  typedef enum logic [13:0] {
    ST_INIT_A    = 14'b00000000000001,
    ST_INIT_B    = 14'b00000000000010,
    ST_INIT_C    = 14'b00000000000100,
    ST_INIT_WAIT = 14'b00000000001000,
    ST_IDLE      = 14'b00000000010000,
    ST_RD        = 14'b00000000100000,
    ST_MUL       = 14'b00000001000000,
    ST_UPD       = 14'b00000010000000,
    ST_NUM_A     = 14'b00000100000000,
    ST_NUM_B     = 14'b00001000000000,
    ST_NUM_C     = 14'b00010000000000,
    ST_NUM_D     = 14'b00100000000000,
    ST_DIV_WAIT  = 14'b01000000000000,
    ST_OUT       = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  // control state
  logic [CFG_W-1:0]        wl_q;
  logic [PTR_W-1:0]        wp_q;
  logic [NW-1:0]           fill_q;
  logic signed [SY_W-1:0]  sum_y_q;
  logic signed [SXY_W-1:0] sum_xy_q;
  logic                    out_valid_q;

  // datapath registers
  logic signed [SAMPLE_BITS-1:0] s_q;
  logic [SAMPLE_BITS-1:0]        rd_q;
  logic signed [PRD_W-1:0]       prod_q;
  logic signed [SY_W-1:0]        d_q;
  logic [N2_W-1:0]               n2_q, sx_q;
  logic [DEN_W-1:0]              x_q, den_q;
  logic signed [DVD_W-1:0]       p1_q, p2_q;
  logic [DVD_W-1:0]              num_q;
  logic                          neg_q;
  logic signed [SLOPE_W-1:0]     slope_q;
  logic                          sat_q;

  logic [SAMPLE_BITS-1:0] ring_mem [MAX_WINDOW];

  logic [NW-1:0]           n;
  logic                    cfg_we, in_acc, restart, full, emit, out_load;
  logic [IDX_W-1:0]        wp_ext, n_ext, idx_ext;
  logic [PTR_W-1:0]        old_idx, wp_nxt;
  logic [NW-1:0]           coef;
  logic signed [PRD_W-1:0] prod_full;
  logic signed [P1_W-1:0]  p1_full;
  logic signed [P2_W-1:0]  p2_full;
  logic [DVD_W-1:0]        mag;
  logic                    div_start;
  logic [DVD_W-1:0]        div_dvd, quot;
  logic [DEN_W-1:0]        div_sor;
  div_stat_t               div_stat;
  logic                    sat_c;
  logic [SLOPE_W-1:0]      qmag;

  // effective window length
  always_comb begin
    if (wl_q < CFG_W'(MIN_WINDOW)) begin
      n = NW'(MIN_WINDOW);
    end else if (32'(wl_q) > 32'(MAX_WINDOW)) begin
      n = NW'(MAX_WINDOW);
    end else begin
      n = NW'(wl_q);
    end
  end

  assign cfg_we      = cfg_i.valid & cfg_i.ready;
  assign cfg_i.ready = 1'b1;
  assign samp_i.ready = (state_q == ST_IDLE) & ~cfg_i.valid;
  assign in_acc      = samp_i.valid & samp_i.ready;
  assign restart     = samp_i.series_start | (fill_q > n);
  assign full        = (fill_q == n);
  assign emit        = full | ((fill_q + NW'(1)) == n);
  assign out_load    = (state_q == ST_OUT) & (~out_valid_q | res_o.ready);

  // slot of the oldest sample, modulo the ring depth
  always_comb begin
    wp_ext  = IDX_W'(wp_q);
    n_ext   = IDX_W'(n);
    idx_ext = (wp_ext >= n_ext) ? wp_ext - n_ext : wp_ext + IDX_W'(MAX_WINDOW) - n_ext;
    old_idx = idx_ext[PTR_W-1:0];
    wp_nxt  = (wp_q == PTR_W'(MAX_WINDOW - 1)) ? '0 : wp_q + 1'b1;
  end

  always_comb begin
    coef      = full ? n - NW'(1) : fill_q;
    prod_full = $signed({1'b0, coef}) * s_q;
    p1_full   = $signed({1'b0, n}) * sum_xy_q;
    p2_full   = $signed({1'b0, sx_q}) * sum_y_q;
    mag       = num_q[DVD_W-1] ? DVD_W'(0) - num_q : num_q;
  end

  always_comb begin
    div_start = (state_q == ST_INIT_C) | (state_q == ST_NUM_D);
    div_dvd   = (state_q == ST_INIT_C) ? DVD_W'(x_q) : mag;
    div_sor   = (state_q == ST_INIT_C) ? DEN_W'(DEN_SCALE) : den_q;
  end

  slrs_div #(
    .DEN_W(DEN_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_sor),
    .stat_o     (div_stat),
    .quotient_o (quot)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT_A:    state_d = ST_INIT_B;
      ST_INIT_B:    state_d = ST_INIT_C;
      ST_INIT_C:    state_d = ST_INIT_WAIT;
      ST_INIT_WAIT: if (div_stat.done) state_d = ST_IDLE;
      ST_IDLE:      if (in_acc) state_d = ST_RD;
      ST_RD:        state_d = ST_MUL;
      ST_MUL:       state_d = ST_UPD;
      ST_UPD:       state_d = emit ? ST_NUM_A : ST_IDLE;
      ST_NUM_A:     state_d = ST_NUM_B;
      ST_NUM_B:     state_d = ST_NUM_C;
      ST_NUM_C:     state_d = ST_NUM_D;
      ST_NUM_D:     state_d = ST_DIV_WAIT;
      ST_DIV_WAIT:  if (div_stat.done) state_d = ST_OUT;
      ST_OUT:       if (out_load) state_d = ST_IDLE;
      default:      state_d = ST_INIT_A;
    endcase
    if (cfg_we) begin
      state_d = ST_INIT_A;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT_A;
      wl_q        <= WINDOW_RESET;
      wp_q        <= '0;
      fill_q      <= '0;
      sum_y_q     <= '0;
      sum_xy_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end
      if (cfg_we) begin
        wl_q     <= cfg_i.window_length;
        wp_q     <= '0;
        fill_q   <= '0;
        sum_y_q  <= '0;
        sum_xy_q <= '0;
      end else if (in_acc && restart) begin
        wp_q     <= '0;
        fill_q   <= '0;
        sum_y_q  <= '0;
        sum_xy_q <= '0;
      end else if (state_q == ST_UPD) begin
        wp_q <= wp_nxt;
        if (full) begin
          sum_y_q  <= d_q + SY_W'(s_q);
          sum_xy_q <= sum_xy_q - SXY_W'(d_q) + SXY_W'(prod_q);
        end else begin
          sum_y_q  <= sum_y_q + SY_W'(s_q);
          sum_xy_q <= sum_xy_q + SXY_W'(prod_q);
          fill_q   <= fill_q + NW'(1);
        end
      end
    end
  end

  // sample ring, registered read into rd_q
  always_ff @(posedge clk_i) begin
    if (state_q == ST_UPD) begin
      ring_mem[wp_q] <= s_q;
    end
    if (state_q == ST_RD) begin
      rd_q <= ring_mem[old_idx];
    end
  end

  always_comb begin
    if (!neg_q) begin
      sat_c = quot > DVD_W'(SLOPE_POS_MAX);
      qmag  = sat_c ? SLOPE_POS_MAX : quot[SLOPE_W-1:0];
    end else begin
      sat_c = quot > DVD_W'(SLOPE_NEG_MAG);
      qmag  = sat_c ? SLOPE_NEG_MAG : quot[SLOPE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s_q <= samp_i.sample;
    end
    case (state_q)
      ST_INIT_A: begin
        n2_q <= N2_W'(n) * N2_W'(n);
        sx_q <= (N2_W'(n) * N2_W'(n - NW'(1))) >> 1;
      end
      ST_INIT_B:    x_q <= DEN_W'(n2_q) * DEN_W'(n2_q - N2_W'(1));
      ST_INIT_WAIT: if (div_stat.done) den_q <= quot[DEN_W-1:0];
      ST_MUL: begin
        prod_q <= prod_full;
        d_q    <= sum_y_q - SY_W'($signed(rd_q));
      end
      ST_NUM_A:     p1_q <= DVD_W'(p1_full);
      ST_NUM_B:     p2_q <= DVD_W'(p2_full);
      ST_NUM_C:     num_q <= p1_q - p2_q;
      ST_NUM_D:     neg_q <= num_q[DVD_W-1];
      ST_OUT: begin
        if (out_load) begin
          slope_q <= neg_q ? SLOPE_W'(0) - qmag : qmag;
          sat_q   <= sat_c;
        end
      end
      default: ;
    endcase
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.slope     = slope_q;
  assign res_o.saturated = sat_q;

  a_den_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (den_q != '0))
    else $error("denominator is zero while taking items");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (fill_q <= n))
    else $error("fill count exceeds the window length");

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !div_stat.busy)
    else $error("divider still busy while idle");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && !cfg_we) |=> (out_valid_q && state_q == ST_IDLE))
    else $error("result load did not register a transaction");

endmodule

>>> tb/slope_checker.sv
// Checker for sliding_linear_regression_slope: snoops the sample, config and
// result channels, predicts each slope and compares it with the block's output.
// Depends on slrs_pkg and the slrs_in_if / slrs_cfg_if / slrs_out_if interfaces.
module slope_checker import slrs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  slrs_in_if   samp_i,
  slrs_cfg_if  cfg_i,
  slrs_out_if  res_i,
  output int   fail_count_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_DEPTH = MAX_WINDOW_DEF;

  typedef struct packed {
    logic [SLOPE_W-1:0] slope;
    logic               saturated;
  } slope_res_t;

  logic [63:0]      ring [RING_DEPTH];
  logic [CFG_W-1:0] window_reg;
  int unsigned      wr_ptr;
  int unsigned      fill_cnt;
  logic [63:0]      sum_y;
  logic [63:0]      sum_xy;
  slope_res_t       pending_slopes [$];

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    fail_count_o++;
  endtask

  task automatic clear_window();
    wr_ptr   = 0;
    fill_cnt = 0;
    sum_y    = '0;
    sum_xy   = '0;
  endtask

  function automatic int unsigned window_eff();
    int unsigned n;
    n = int'(window_reg);
    if (n < MIN_WINDOW) n = MIN_WINDOW;
    if (n > MAX_WINDOW_DEF) n = MAX_WINDOW_DEF;
    return n;
  endfunction

  // Update the window with one sample; queue the slope once the window is full.
  task automatic advance_window(input logic [SAMPLE_BITS_DEF-1:0] smp, input logic start);
    int unsigned n;
    logic [63:0] y, y0, nn, sx, sxx, den, num, mag, q;
    logic        neg;
    slope_res_t  r;
    n = window_eff();
    y = {{(64-SAMPLE_BITS_DEF){smp[SAMPLE_BITS_DEF-1]}}, smp};
    if (start) clear_window();
    if (fill_cnt > n) clear_window();
    if (fill_cnt < n) begin
      sum_y  = sum_y + y;
      sum_xy = sum_xy + 64'(fill_cnt) * y;
      fill_cnt++;
    end else begin
      // oldest sample leaves at x=0, every other x drops by one
      y0     = ring[(wr_ptr + RING_DEPTH - n) % RING_DEPTH];
      sum_xy = sum_xy - (sum_y - y0) + 64'(n - 1) * y;
      sum_y  = sum_y - y0 + y;
    end
    ring[wr_ptr] = y;
    wr_ptr = (wr_ptr + 1) % RING_DEPTH;
    if (fill_cnt >= n) begin
      nn  = 64'(n);
      sx  = nn * (nn - 64'd1) / 64'd2;
      sxx = nn * (nn - 64'd1) * (64'd2 * nn - 64'd1) / 64'd6;
      den = nn * sxx - sx * sx;
      num = nn * sum_xy - sx * sum_y;
      neg = num[63];
      mag = neg ? -num : num;
      q   = mag / den;
      r.saturated = 1'b0;
      if (!neg) begin
        if (q > 64'(SLOPE_POS_MAX)) begin
          q = 64'(SLOPE_POS_MAX);
          r.saturated = 1'b1;
        end
        r.slope = q[SLOPE_W-1:0];
      end else begin
        if (q > 64'(SLOPE_NEG_MAG)) begin
          q = 64'(SLOPE_NEG_MAG);
          r.saturated = 1'b1;
        end
        r.slope = SLOPE_W'(-q);
      end
      pending_slopes.push_back(r);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    slope_res_t want;
    if (!rst_ni) begin
      window_reg = WINDOW_RESET;
      clear_window();
      pending_slopes.delete();
      fail_count_o = 0;
      pending_o <= 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        if (pending_slopes.size() == 0) begin
          report_mismatch($sformatf("unexpected result slope=%0d sat=%0b",
                                    res_i.slope, res_i.saturated));
        end else begin
          want = pending_slopes.pop_front();
          if (res_i.slope !== want.slope)
            report_mismatch($sformatf("slope got %0d want %0d",
                                      res_i.slope, $signed(want.slope)));
          if (res_i.saturated !== want.saturated)
            report_mismatch($sformatf("saturated got %0b want %0b (slope %0d)",
                                      res_i.saturated, want.saturated,
                                      $signed(want.slope)));
        end
      end
      // a config write always restarts the series
      if (cfg_i.valid && cfg_i.ready) begin
        window_reg = cfg_i.window_length;
        clear_window();
      end
      if (samp_i.valid && samp_i.ready)
        advance_window(samp_i.sample, samp_i.series_start);
      pending_o <= pending_slopes.size();
    end
  end

endmodule

>>> tb/tb.sv
// Top of the sliding_linear_regression_slope testbench: clock, reset, sample and
// config stimulus, result back-pressure, watchdog and verdict.
// Depends on slrs_pkg, the slrs_*_if interfaces, the block and slope_checker.
module tb import slrs_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_PHASES  = 13;
  localparam int SETTLE_CYC  = 100;   // > slope latency, covers a fill-only tail
  localparam int STALL_LIMIT = 3000;  // cycles without any transaction

  typedef enum logic [1:0] {SEG_RAMP, SEG_NOISE, SEG_SMALL, SEG_EXTREME} seg_kind_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic res_ready = 1'b0;
  int   fail_count;
  int   pending;

  // sample shaping state, one segment at a time
  seg_kind_e          seg_kind  = SEG_RAMP;
  int unsigned        seg_left  = 0;
  logic signed [31:0] ramp_val  = '0;
  logic signed [31:0] ramp_step = '0;
  bit                 tx_burst  = 1'b0;
  bit                 rx_calm   = 1'b0;
  int unsigned        res_hold  = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  slrs_in_if #(.SAMPLE_BITS(SAMPLE_BITS_DEF)) samp_if ();
  slrs_cfg_if cfg_if ();
  slrs_out_if res_if ();

  assign res_if.ready = res_ready;

  sliding_linear_regression_slope DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .samp_i (samp_if),
    .cfg_i  (cfg_if),
    .res_o  (res_if)
  );

  slope_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .samp_i       (samp_if),
    .cfg_i        (cfg_if),
    .res_i        (res_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // result sink: hold ready low for a drawn number of cycles of valid
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ready <= 1'b0;
      res_hold = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if ($urandom_range(0, 19) == 0) rx_calm = !rx_calm;
        res_hold = rx_calm ? 0 : $urandom_range(0, 3);
      end else if (res_if.valid && res_hold != 0) begin
        res_hold--;
      end
      res_ready <= (res_hold == 0);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((samp_if.valid && samp_if.ready) || (cfg_if.valid && cfg_if.ready) ||
          (res_if.valid && res_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("sliding_linear_regression_slope test failed");
    $finish;
  end

  task automatic send_sample(input logic [31:0] smp, input logic start);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      samp_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    samp_if.valid        <= 1'b1;
    samp_if.sample       <= smp;
    samp_if.series_start <= start;
    do @(posedge clk_i); while (!samp_if.ready);
  endtask

  task automatic write_window(input logic [CFG_W-1:0] len);
    cfg_if.valid         <= 1'b1;
    cfg_if.window_length <= len;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  // pending is registered in the checker, so poll it only after the next clock edge
  task automatic drain_results();
    samp_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic draw_sample(output logic [31:0] smp);
    int unsigned pick;
    if (seg_left == 0) begin
      pick = $urandom_range(0, 9);
      seg_kind  = (pick < 5) ? SEG_RAMP : (pick < 7) ? SEG_NOISE :
                  (pick < 9) ? SEG_SMALL : SEG_EXTREME;
      seg_left  = $urandom_range(8, 40);
      ramp_val  = $signed($urandom()) >>> $urandom_range(0, 8);
      ramp_step = $signed($urandom()) >>> $urandom_range(8, 24);
      tx_burst  = ($urandom_range(0, 3) == 0);
    end
    seg_left--;
    case (seg_kind)
      SEG_RAMP: begin
        ramp_val = ramp_val + ramp_step;
        smp = ramp_val + ($urandom_range(0, 255) - 128);
      end
      SEG_NOISE: smp = $urandom();
      SEG_SMALL: smp = $urandom_range(0, 1023) - 512;
      default: begin
        case ($urandom_range(0, 3))
          0:       smp = 32'h7FFF_FFFF;
          1:       smp = 32'h8000_0000;
          2:       smp = '0;
          default: smp = '1;
        endcase
      end
    endcase
  endtask

  initial begin : stimulus
    logic [31:0]      warmup [16];
    logic [31:0]      pair_smp [9];
    bit               pair_start [9];
    logic [CFG_W-1:0] plan_win [NUM_PHASES];
    int unsigned      plan_len [NUM_PHASES];
    logic [CFG_W-1:0] win;
    logic [31:0]      smp;
    int unsigned      eff, restart_odds;

    samp_if.valid        <= 1'b0;
    samp_if.sample       <= '0;
    samp_if.series_start <= 1'b0;
    cfg_if.valid         <= 1'b0;
    cfg_if.window_length <= '0;

    warmup = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
               32'h0000_0001, 32'h0001_0000, 32'hFFFF_0000, 32'h5555_5555,
               32'hAAAA_AAAA, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
               32'h8000_0000, 32'h0000_0000, 32'h1234_5678, 32'hDEAD_BEEF};
    // window of 2: slope is the difference, so both clip edges are exact
    pair_smp   = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
                   32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000,
                   32'h8000_0000};
    pair_start = '{1, 0, 0, 1, 0, 0, 0, 1, 0};
    plan_win = '{9'd2, 9'd3, 9'd14, 9'd0, 9'd1, 9'd256, 9'd5, 9'd511, 9'd31,
                 9'd8, 9'd64, 9'd2, 9'd0};
    plan_len = '{100, 100, 100, 80, 80, 290, 100, 280, 100, 100, 120, 60, 100};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset window length, field extremes, restart on a full window
    foreach (warmup[i]) send_sample(warmup[i], 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b1);
    send_sample(32'h8000_0000, 1'b0);
    drain_results();

    write_window(9'd2);
    foreach (pair_smp[i]) send_sample(pair_smp[i], pair_start[i]);
    drain_results();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      win = (ph == NUM_PHASES - 1) ? CFG_W'($urandom_range(2, 20)) : plan_win[ph];
      eff = (win < MIN_WINDOW) ? MIN_WINDOW :
            (win > MAX_WINDOW_DEF) ? MAX_WINDOW_DEF : int'(win);
      restart_odds = (eff > 40) ? 600 : 40;
      write_window(win);
      for (int k = 0; k < plan_len[ph]; k++) begin
        draw_sample(smp);
        send_sample(smp, ($urandom_range(1, restart_odds) == 1));
      end
      drain_results();
    end

    if (fail_count == 0)
      $display("sliding_linear_regression_slope test passed");
    else
      $display("sliding_linear_regression_slope test failed");
    $finish;
  end

endmodule
